FILE: design/pbrt_pkg.sv
// Package for the pinned bucket reference tracker: widths, codes and queue record.
// No dependencies.
`default_nettype none
package pbrt_pkg;
	localparam int ENTRIES_DEF = 1024;
	localparam int NODES_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int NODE_W = 4;
	localparam int IDX_W = 10;
	localparam int CNT_OUT_W = 11;
	localparam logic [CNT_OUT_W-1:0] LONLY_MAX = 11'd2047;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_BAD = 3'd2;
	localparam logic [2:0] ST_REMOTE_BY_LOCAL = 3'd3;
	localparam logic [2:0] ST_IDLE_LOCAL = 3'd4;

	localparam logic [1:0] PL_USE = 2'd0;
	localparam logic [1:0] PL_LFIFO = 2'd1;
	localparam logic [1:0] PL_RFIFO = 2'd2;

	typedef enum logic [1:0] {
		OP_LOCAL_REF,
		OP_LOCAL_OTHER,
		OP_REMOTE,
		OP_REMOTE_BY_LOCAL
	} kind_t;

	typedef struct packed {
		logic rel;
		kind_t kind;
		logic [IDX_W-1:0] entry;
		logic [NODE_W-1:0] node;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LINKS,
		S_EXEC,
		S_FIX,
		S_OUT,
		S_INIT
	} exec_state_t;
endpackage
`default_nettype wire

FILE: design/pbrt_front.sv
// Front end: accepts words, classifies ownership and queues commands.
// Depends on pbrt_pkg.
`default_nettype none
module pbrt_front
	import pbrt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [NODE_W-1:0] local_node,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata,
	output logic q_valid,
	input wire logic q_ready,
	output cmd_t q_cmd
);
	cmd_t buf_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	cmd_t c;
	logic push, pop;
	logic [NODE_W-1:0] req, own;

	always_comb begin
		req = s_tdata[14:11];
		own = s_tdata[18:15];
		c.rel = s_tdata[0];
		c.entry = s_tdata[10:1];
		c.node = req;
		if (own == local_node)
			c.kind = (req == local_node) ? OP_LOCAL_REF : OP_LOCAL_OTHER;
		else
			c.kind = (req == local_node) ? OP_REMOTE_BY_LOCAL : OP_REMOTE;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

FILE: design/pbrt_back.sv
// Back end: read-modify-write of entry, links, FIFO ends and counters.
// Depends on pbrt_pkg.
`default_nettype none
module pbrt_back
	import pbrt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire cmd_t q_cmd,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [87:0] m_tdata
);
	localparam int ENTRIES = ENTRIES_DEF;
	localparam int NODES = NODES_DEF;
	localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
	localparam int EW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [LW-1:0] NUL = LW'(ENTRIES);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	// entry memory: cleared by a pass over all entries after reset
	logic [COUNT_WIDTH-1:0] lc_mem [ENTRIES];
	logic [COUNT_WIDTH-1:0] rc_mem [ENTRIES];
	logic [1:0] pl_mem [ENTRIES];
	logic [LW-1:0] nx_mem [ENTRIES];
	logic [LW-1:0] pv_mem [ENTRIES];
	logic [EW-1:0] clr_q;

	logic [LW-1:0] lhead_q, ltail_q;
	logic [LW-1:0] rhead_q [NODES];
	logic [LW-1:0] rtail_q [NODES];
	logic [CNT_OUT_W-1:0] lonly_q, lvict_q;
	logic [CNT_OUT_W-1:0] rvict_q [NODES];

	exec_state_t st_q, st_d;
	cmd_t cmd_q;
	logic [EW-1:0] e;
	logic [NW-1:0] nd;
	logic [COUNT_WIDTH-1:0] lc_q, rc_q;
	logic [1:0] pl_q;
	logic [LW-1:0] nx_q, pv_q, pn_q, np_q;
	logic [2:0] sts_q;
	logic [87:0] out_q;
	logic ovld_q;

	assign e = cmd_q.entry;
	assign nd = cmd_q.node;

	logic is_loc;
	logic [LW-1:0] fhead, ftail;
	assign is_loc = (cmd_q.kind == OP_LOCAL_REF) || (cmd_q.kind == OP_LOCAL_OTHER);
	assign fhead = is_loc ? lhead_q : rhead_q[nd];
	assign ftail = is_loc ? ltail_q : rtail_q[nd];

	// decision
	logic [2:0] s;
	logic do_unlink, do_append, ref_l;
	logic [COUNT_WIDTH-1:0] nlc, nrc;
	logic [1:0] npl;
	logic lo_dec, lo_inc, lv_dec, lv_inc, rv_dec, rv_inc, canu;

	always_comb begin
		ref_l = (cmd_q.kind == OP_LOCAL_REF);
		canu = 1'b1;
		if (pv_q == NUL) begin
			if (fhead != LW'(e)) canu = 1'b0;
		end else if (pv_q > NUL || pn_q != LW'(e)) canu = 1'b0;
		if (nx_q == NUL) begin
			if (ftail != LW'(e)) canu = 1'b0;
		end else if (nx_q > NUL || np_q != LW'(e)) canu = 1'b0;
		s = ST_OK;
		do_unlink = 1'b0; do_append = 1'b0;
		nlc = lc_q; nrc = rc_q; npl = pl_q;
		lo_dec = 1'b0; lo_inc = 1'b0; lv_dec = 1'b0; lv_inc = 1'b0;
		rv_dec = 1'b0; rv_inc = 1'b0;
		unique case (cmd_q.kind)
			OP_REMOTE_BY_LOCAL: s = ST_REMOTE_BY_LOCAL;
			OP_LOCAL_REF, OP_LOCAL_OTHER: begin
				if (!cmd_q.rel) begin
					if (pl_q == PL_LFIFO) begin
						if (!canu) s = ST_BAD;
						else begin
							do_unlink = 1'b1;
							nlc = ref_l ? COUNT_WIDTH'(1) : '0;
							nrc = ref_l ? '0 : COUNT_WIDTH'(1);
							lo_dec = !ref_l; lv_dec = 1'b1; npl = PL_USE;
						end
					end else if (pl_q != PL_USE) s = ST_BAD;
					else if (ref_l) begin
						if (lc_q == CMAX) s = ST_OVERFLOW;
						else nlc = lc_q + 1'b1;
					end else if (rc_q == CMAX) s = ST_OVERFLOW;
					else if (rc_q == '0 && lc_q == '0) s = ST_IDLE_LOCAL;
					else begin
						lo_dec = (rc_q == '0);
						nrc = rc_q + 1'b1;
					end
				end else begin
					if (pl_q != PL_USE) s = ST_BAD;
					else if (ref_l ? lc_q == '0 : rc_q == '0) s = ST_BAD;
					else begin
						if (ref_l) nlc = lc_q - 1'b1; else nrc = rc_q - 1'b1;
						if (nlc == '0 && nrc == '0) begin
							do_append = 1'b1; lo_inc = !ref_l; lv_inc = 1'b1;
							npl = PL_LFIFO;
						end else if (nrc == '0 && !ref_l) lo_inc = 1'b1;
					end
				end
			end
			default: begin
				if (!cmd_q.rel) begin
					if (pl_q == PL_RFIFO) begin
						if (!canu) s = ST_BAD;
						else begin
							do_unlink = 1'b1; rv_dec = 1'b1;
							nlc = '0; nrc = COUNT_WIDTH'(1); npl = PL_USE;
						end
					end else if (pl_q != PL_USE) s = ST_BAD;
					else if (rc_q == CMAX) s = ST_OVERFLOW;
					else nrc = rc_q + 1'b1;
				end else if (pl_q != PL_USE || rc_q == '0) s = ST_BAD;
				else begin
					nrc = rc_q - 1'b1;
					if (nrc == '0) begin
						do_append = 1'b1; rv_inc = 1'b1; npl = PL_RFIFO;
					end
				end
			end
		endcase
	end

	// second write of unlink/append (neighbor link) done in S_FIX
	logic fix_nx_en, fix_pv_en;
	logic [EW-1:0] fix_nx_a, fix_pv_a;
	logic [LW-1:0] fix_nx_d, fix_pv_d;
	logic fix_nx_q, fix_pv_q;
	logic [EW-1:0] fxa_q, fpa_q;
	logic [LW-1:0] fxd_q, fpd_q;

	always_comb begin
		fix_nx_en = 1'b0; fix_pv_en = 1'b0;
		fix_nx_a = EW'(pv_q); fix_nx_d = nx_q;
		fix_pv_a = EW'(nx_q); fix_pv_d = pv_q;
		if (do_unlink) begin
			fix_nx_en = (pv_q != NUL);
			fix_pv_en = (nx_q != NUL);
		end else if (do_append) begin
			fix_nx_en = (ftail != NUL);
			fix_nx_a = EW'(ftail);
			fix_nx_d = LW'(e);
		end
	end

	logic [CNT_OUT_W-1:0] lonly_n, lvict_n, rvict_n;
	logic [LW-1:0] head_n;

	always_comb begin
		st_d = st_q;
		q_ready = 1'b0;
		unique case (st_q)
			S_INIT: if (clr_q == EW'(ENTRIES - 1)) st_d = S_IDLE;
			S_IDLE: begin
				q_ready = !ovld_q;
				if (q_valid && !ovld_q) st_d = S_READ;
			end
			S_READ: st_d = S_LINKS;
			S_LINKS: st_d = S_EXEC;
			S_EXEC: st_d = S_FIX;
			S_FIX: st_d = S_OUT;
			S_OUT: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_INIT;
		else st_q <= st_d;
	end

	// walk every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (st_q == S_INIT) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) cmd_q <= q_cmd;
		if (st_q == S_INIT) begin
			lc_mem[clr_q] <= '0;
			rc_mem[clr_q] <= '0;
			pl_mem[clr_q] <= PL_USE;
			nx_mem[clr_q] <= NUL;
			pv_mem[clr_q] <= NUL;
		end
		if (st_q == S_READ) begin
			lc_q <= lc_mem[e];
			rc_q <= rc_mem[e];
			pl_q <= pl_mem[e];
			nx_q <= nx_mem[e];
			pv_q <= pv_mem[e];
		end
		if (st_q == S_LINKS) begin
			pn_q <= (pv_q < NUL) ? nx_mem[EW'(pv_q)] : NUL;
			np_q <= (nx_q < NUL) ? pv_mem[EW'(nx_q)] : NUL;
		end
		if (st_q == S_EXEC) begin
			sts_q <= s;
			fix_nx_q <= (s == ST_OK) && fix_nx_en; fxa_q <= fix_nx_a; fxd_q <= fix_nx_d;
			fix_pv_q <= (s == ST_OK) && fix_pv_en; fpa_q <= fix_pv_a; fpd_q <= fix_pv_d;
			if (s == ST_OK) begin
				lc_mem[e] <= nlc;
				rc_mem[e] <= nrc;
				pl_mem[e] <= npl;
				lc_q <= nlc; rc_q <= nrc; pl_q <= npl;
				if (do_unlink || do_append) begin
					nx_mem[e] <= NUL;
					pv_mem[e] <= do_append ? ftail : NUL;
				end else begin
					nx_mem[e] <= nx_q;
					pv_mem[e] <= pv_q;
				end
			end
		end
		if (st_q == S_FIX) begin
			if (fix_nx_q) nx_mem[fxa_q] <= fxd_q;
			if (fix_pv_q) pv_mem[fpa_q] <= fpd_q;
		end
		if (st_q == S_OUT) out_q <= {7'b0, head_n, rvict_n, lvict_n, lonly_n,
			pl_q, 16'(rc_q), 16'(lc_q), sts_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lhead_q <= NUL; ltail_q <= NUL;
			lonly_q <= '0; lvict_q <= '0;
			for (int i = 0; i < NODES; i++) begin
				rhead_q[i] <= NUL; rtail_q[i] <= NUL; rvict_q[i] <= '0;
			end
		end else if (st_q == S_EXEC && s == ST_OK) begin
			if (lo_dec && lonly_q != '0) lonly_q <= lonly_q - 1'b1;
			if (lo_inc && lonly_q != LONLY_MAX) lonly_q <= lonly_q + 1'b1;
			if (lv_dec && lvict_q != '0) lvict_q <= lvict_q - 1'b1;
			if (lv_inc) lvict_q <= lvict_q + 1'b1;
			if (rv_dec && rvict_q[nd] != '0) rvict_q[nd] <= rvict_q[nd] - 1'b1;
			if (rv_inc) rvict_q[nd] <= rvict_q[nd] + 1'b1;
			if (do_unlink) begin
				if (is_loc) begin
					if (pv_q == NUL) lhead_q <= nx_q;
					if (nx_q == NUL) ltail_q <= pv_q;
				end else begin
					if (pv_q == NUL) rhead_q[nd] <= nx_q;
					if (nx_q == NUL) rtail_q[nd] <= pv_q;
				end
			end else if (do_append) begin
				if (is_loc) begin
					if (ltail_q == NUL) lhead_q <= LW'(e);
					ltail_q <= LW'(e);
				end else begin
					if (rtail_q[nd] == NUL) rhead_q[nd] <= LW'(e);
					rtail_q[nd] <= LW'(e);
				end
			end
		end
	end

	assign lonly_n = lonly_q;
	assign lvict_n = lvict_q;
	assign rvict_n = rvict_q[nd];
	assign head_n = is_loc ? lhead_q : rhead_q[nd];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (st_q == S_OUT) ovld_q <= 1'b1;
		else if (m_tready) ovld_q <= 1'b0;
	end

	assign m_tvalid = ovld_q;
	assign m_tdata = out_q;
endmodule
`default_nettype wire

FILE: design/pinned_bucket_refcount_tracker_unit.sv
// Pinned bucket reference tracker, top level.
// One item at a time: the back end does the entry/link read-modify-write in the steps
// read, link read, execute and fix-up, then outputs, and takes no new command until
// the result word has been taken.
// Reset: asynchronous, clears counters and FIFO ends; then a pass over all 1024 entries
// clears the entry tables, during which the back end takes no word.
`default_nettype none
module pinned_bucket_refcount_tracker_unit
	import pbrt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [3:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	// operation, entry_index[10], requester_node[4], entry_owner_node[4], pad
	input wire logic [23:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// status[3], refc_local[16], refc_remote[16], entry_place[2],
	// local_only_pinned[11], local_victims[11], node_victims[11], oldest_victim[11], pad
	output logic [87:0] m_tdata
);
	logic [NODE_W-1:0] local_node_q;
	logic q_valid, q_ready;
	cmd_t q_cmd;

	// hold the node number; the user must write it only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) local_node_q <= '0;
		else if (cfg_we) local_node_q <= cfg_wdata;
	end

	pbrt_front u_front (
		.clk, .arst_n, .local_node(local_node_q),
		.s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_ready, .q_cmd
	);

	pbrt_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.m_tvalid, .m_tready, .m_tdata
	);

`ifndef SYNTH
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_IDLE_LOCAL) else $error("bad status");
	a_place_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[36:35] != 2'd3) else $error("bad place");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
